// ===== design/icv_pkg.sv =====
// shared constants and tables for the isotropic collision velocity block
// no dependencies; imported by icv_isqrt, icv_cordic, the top level and the testbench
package icv_pkg;

    // field widths
    localparam int VelW      = 32;
    localparam int RandBits  = 16;
    localparam int InDataW   = 6 * VelW + 2 * RandBits;
    localparam int OutDataW  = 6 * VelW;

    // trig and square-root formats
    localparam int TrigFrac    = 30;
    localparam int CordicSteps = 24;
    localparam int CordicW     = 33;
    localparam int SqrtInW     = 64;
    localparam int SqrtOutW    = 32;
    localparam logic signed [CordicW-1:0] CordicGainInv = 33'sd652032874;

    // pipeline timing: front end, square root, back end
    localparam int FrontStages = 3;
    localparam int SqrtStages  = SqrtOutW;
    localparam int CordicLat   = CordicSteps + 1;
    localparam int TrigReady   = FrontStages + SqrtStages;
    localparam int AzDelay     = TrigReady - 1 - CordicLat;
    localparam int CmDelay     = TrigReady - 1;
    localparam int PipeDepth   = TrigReady + 3;

    // arctangent of 2^-i in turns, scaled by 2^32
    function automatic logic signed [31:0] turn_atan(input int idx);
        logic signed [31:0] a;
        case (idx)
            0:       a = 32'h20000000;
            1:       a = 32'h12e4051d;
            2:       a = 32'h09fb385b;
            3:       a = 32'h051111d4;
            4:       a = 32'h028b0d43;
            5:       a = 32'h0145d7e1;
            6:       a = 32'h00a2f61e;
            7:       a = 32'h00517c55;
            8:       a = 32'h0028be53;
            9:       a = 32'h00145f2e;
            10:      a = 32'h000a2f98;
            11:      a = 32'h000517cc;
            12:      a = 32'h00028be6;
            13:      a = 32'h000145f3;
            14:      a = 32'h0000a2f9;
            15:      a = 32'h0000517c;
            16:      a = 32'h000028be;
            17:      a = 32'h0000145f;
            18:      a = 32'h00000a2f;
            19:      a = 32'h00000517;
            20:      a = 32'h0000028b;
            21:      a = 32'h00000145;
            22:      a = 32'h000000a2;
            23:      a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ===== design/icv_delay.sv =====
// enabled shift-register delay line for payload that rides beside the math
// depends on nothing but the clock and the pipeline enable
module icv_delay #(
    parameter int W = 32,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_tap [D];

    // tap chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < D; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[D-1];

endmodule

// ===== design/icv_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on icv_pkg for the radicand and root widths
module icv_isqrt
    import icv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SqrtInW-1:0]  i_radicand,
    output logic [SqrtOutW-1:0] o_root
);

    logic [SqrtInW-1:0]  r_n    [SqrtOutW];
    logic [SqrtOutW+1:0] r_rem  [SqrtOutW];
    logic [SqrtOutW-1:0] r_root [SqrtOutW];

    for (genvar k = 0; k < SqrtOutW; k++) begin : g_stage
        logic [SqrtInW-1:0]  src_n;
        logic [SqrtOutW+1:0] src_rem;
        logic [SqrtOutW-1:0] src_root;
        logic [SqrtOutW+1:0] rem_sh;
        logic [SqrtOutW+1:0] trial;

        if (k == 0) begin : g_first
            assign src_n    = i_radicand;
            assign src_rem  = '0;
            assign src_root = '0;
        end else begin : g_next
            assign src_n    = r_n[k-1];
            assign src_rem  = r_rem[k-1];
            assign src_root = r_root[k-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_sh = {src_rem[SqrtOutW-1:0], src_n[SqrtInW-1 -: 2]};
        assign trial  = {src_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k] <= src_n << 2;
                if (rem_sh >= trial) begin
                    r_rem[k]  <= rem_sh - trial;
                    r_root[k] <= {src_root[SqrtOutW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem_sh;
                    r_root[k] <= {src_root[SqrtOutW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SqrtOutW-1];

endmodule

// ===== design/icv_cordic.sv =====
// pipelined rotation cordic giving cosine and sine of an azimuth fraction
// depends on icv_pkg for the arctangent table, gain and widths
module icv_cordic
    import icv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [RandBits-1:0] i_frac,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin
);

    logic signed [CordicW-1:0] r_x [CordicSteps];
    logic signed [CordicW-1:0] r_y [CordicSteps];
    logic signed [31:0]        r_z [CordicSteps];
    logic [1:0]                r_quad [CordicSteps];
    logic signed [31:0]        r_cos;
    logic signed [31:0]        r_sin;
    logic [31:0]               phase;

    // fraction of a turn as a 32-bit phase
    assign phase = {i_frac, {(32 - RandBits){1'b0}}};

    for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
        logic signed [CordicW-1:0] src_x;
        logic signed [CordicW-1:0] src_y;
        logic signed [31:0]        src_z;
        logic [1:0]                src_quad;
        logic signed [CordicW-1:0] xs;
        logic signed [CordicW-1:0] ys;

        if (i == 0) begin : g_first
            assign src_x    = CordicGainInv;
            assign src_y    = '0;
            assign src_z    = $signed({2'b00, phase[29:0]});
            assign src_quad = phase[31:30];
        end else begin : g_next
            assign src_x    = r_x[i-1];
            assign src_y    = r_y[i-1];
            assign src_z    = r_z[i-1];
            assign src_quad = r_quad[i-1];
        end

        assign xs = src_x >>> i;
        assign ys = src_y >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quad[i] <= src_quad;
                if (src_z >= 0) begin
                    r_x[i] <= src_x - ys;
                    r_y[i] <= src_y + xs;
                    r_z[i] <= src_z - turn_atan(i);
                end else begin
                    r_x[i] <= src_x + ys;
                    r_y[i] <= src_y - xs;
                    r_z[i] <= src_z + turn_atan(i);
                end
            end
        end
    end

    // quadrant fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_quad[CordicSteps-1])
                2'd0: begin
                    r_cos <= r_x[CordicSteps-1][31:0];
                    r_sin <= r_y[CordicSteps-1][31:0];
                end
                2'd1: begin
                    r_cos <= -r_y[CordicSteps-1][31:0];
                    r_sin <= r_x[CordicSteps-1][31:0];
                end
                2'd2: begin
                    r_cos <= -r_x[CordicSteps-1][31:0];
                    r_sin <= -r_y[CordicSteps-1][31:0];
                end
                default: begin
                    r_cos <= r_y[CordicSteps-1][31:0];
                    r_sin <= -r_x[CordicSteps-1][31:0];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== design/isotropic_collision_velocities.sv =====
// top level of the isotropic hard-sphere collision velocity pipeline
// depends on icv_pkg, icv_delay, icv_isqrt and icv_cordic
//
// Takes one particle pair per clock while the output is not stalled and returns one
// result per pair. The result path runs through the two 32-stage square-root
// pipelines (relative speed and polar sine) plus three front stages (difference,
// square, sum) and three back stages (direction, offset, saturating add). The
// cordic for the azimuth runs in parallel. A stall on the output freezes the
// whole pipeline; s_axis_tready is low only while the last stage holds a result
// that has not been taken.
module isotropic_collision_velocities
    import icv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // first_vx, first_vy, first_vz, second_vx, second_vy, second_vz,
    // azimuth_fraction, polar_fraction
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // new_first_vx, new_first_vy, new_first_vz,
    // new_second_vx, new_second_vy, new_second_vz
    output logic [OutDataW-1:0] m_axis_tdata
);

    logic                       adv;
    logic [PipeDepth:1]         r_vld;

    // stage 1
    logic signed [VelW:0]       r_d  [3];
    logic [3*VelW-1:0]          r_cm1;
    logic [RandBits-1:0]        r_u;
    logic [RandBits-1:0]        r_v;
    // stage 2
    logic [2*VelW+1:0]          r_sq [3];
    logic [2*RandBits+1:0]      r_prod;
    // stage 3
    logic [SqrtInW-1:0]         r_quarter;
    logic [SqrtInW-1:0]         r_prod_sh;
    // trig ready
    logic [SqrtOutW-1:0]        radius;
    logic [SqrtOutW-1:0]        sin_p;
    logic signed [31:0]         cos_t;
    logic signed [31:0]         sin_t;
    logic [RandBits-1:0]        u_dly;
    logic [3*VelW-1:0]          cm_dly;
    logic [RandBits-1:0]        v_dly;
    // back end
    logic signed [31:0]         r_dir [3];
    logic [SqrtOutW-1:0]        r_rad;
    logic [3*VelW-1:0]          r_cm36;
    logic signed [VelW+2:0]     r_off [3];
    logic [3*VelW-1:0]          r_cm37;
    logic [OutDataW-1:0]        r_out;

    // whole pipeline moves unless the last result is held
    assign adv           = !r_vld[PipeDepth] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[PipeDepth];
    assign m_axis_tdata  = r_out;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PipeDepth-1:1], s_axis_tvalid};
        end
    end

    // stage 1: differences and center of mass
    always_ff @(posedge i_clk) begin
        logic signed [VelW:0] a;
        logic signed [VelW:0] b;
        logic signed [VelW:0] s;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                a = $signed({s_axis_tdata[k*VelW + VelW-1], s_axis_tdata[k*VelW +: VelW]});
                b = $signed({s_axis_tdata[(k+3)*VelW + VelW-1],
                             s_axis_tdata[(k+3)*VelW +: VelW]});
                s = a + b;
                r_d[k] <= a - b;
                r_cm1[k*VelW +: VelW] <= s[VelW:1];
            end
            r_u <= s_axis_tdata[6*VelW +: RandBits];
            r_v <= s_axis_tdata[6*VelW + RandBits +: RandBits];
        end
    end

    // stage 2: squares and polar product
    always_ff @(posedge i_clk) begin
        logic [VelW:0]     mag;
        logic [RandBits:0] rest;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                mag = r_d[k][VelW] ? (VelW+1)'(0) - r_d[k] : r_d[k];
                r_sq[k] <= {{(VelW+1){1'b0}}, mag} * {{(VelW+1){1'b0}}, mag};
            end
            rest   = (RandBits+1)'(1 << RandBits) - {1'b0, r_v};
            r_prod <= {{(RandBits+1){1'b0}}, 1'b0, r_v} * {{(RandBits+1){1'b0}}, rest};
        end
    end

    // stage 3: floor of the quarter sum, scaled polar product
    always_ff @(posedge i_clk) begin
        logic [2*VelW+1:0] acc;
        logic [3:0]        low;
        if (adv) begin
            low = {2'b00, r_sq[0][1:0]} + {2'b00, r_sq[1][1:0]} + {2'b00, r_sq[2][1:0]};
            acc = (r_sq[0] >> 2) + (r_sq[1] >> 2) + (r_sq[2] >> 2)
                + {{(2*VelW){1'b0}}, low[3:2]};
            r_quarter <= acc[SqrtInW-1:0];
            r_prod_sh <= SqrtInW'(r_prod) << (62 - 2 * RandBits);
        end
    end

    icv_isqrt u_rad_sqrt (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_radicand (r_quarter),
        .o_root     (radius)
    );

    icv_isqrt u_sin_sqrt (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_radicand (r_prod_sh),
        .o_root     (sin_p)
    );

    icv_delay #(.W(RandBits), .D(AzDelay)) u_az_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (r_u),
        .o_data (u_dly)
    );

    icv_cordic u_cordic (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_frac (u_dly),
        .o_cos  (cos_t),
        .o_sin  (sin_t)
    );

    icv_delay #(.W(3*VelW), .D(CmDelay)) u_cm_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (r_cm1),
        .o_data (cm_dly)
    );

    icv_delay #(.W(RandBits), .D(CmDelay)) u_v_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (r_v),
        .o_data (v_dly)
    );

    // direction vector
    always_ff @(posedge i_clk) begin
        logic signed [64:0]       pc;
        logic signed [64:0]       ps;
        logic signed [RandBits+1:0] w;
        if (adv) begin
            pc = cos_t * $signed({1'b0, sin_p});
            ps = sin_t * $signed({1'b0, sin_p});
            w  = $signed({1'b0, v_dly, 1'b0}) - $signed((RandBits+2)'(1 << RandBits));
            r_dir[0] <= pc[TrigFrac+31:TrigFrac];
            r_dir[1] <= ps[TrigFrac+31:TrigFrac];
            r_dir[2] <= 32'({w, {(TrigFrac - RandBits){1'b0}}});
            r_rad    <= radius;
            r_cm36   <= cm_dly;
        end
    end

    // offsets
    always_ff @(posedge i_clk) begin
        logic signed [64:0] p;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                p = $signed({1'b0, r_rad}) * r_dir[k];
                r_off[k] <= p[TrigFrac+VelW+2:TrigFrac];
            end
            r_cm37 <= r_cm36;
        end
    end

    // saturating sums
    always_ff @(posedge i_clk) begin
        logic signed [VelW+3:0] cmx;
        logic signed [VelW+3:0] sp;
        logic signed [VelW+3:0] sm;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                cmx = {{4{r_cm37[k*VelW + VelW-1]}}, r_cm37[k*VelW +: VelW]};
                sp  = cmx + {r_off[k][VelW+2], r_off[k]};
                sm  = cmx - {r_off[k][VelW+2], r_off[k]};
                if (sp > $signed({4'b0000, {(VelW-1){1'b1}}, 1'b1} >>> 1)) begin
                    r_out[k*VelW +: VelW] <= {1'b0, {(VelW-1){1'b1}}};
                end else if (sp < -$signed({4'b0000, 1'b1, {(VelW-1){1'b0}}})) begin
                    r_out[k*VelW +: VelW] <= {1'b1, {(VelW-1){1'b0}}};
                end else begin
                    r_out[k*VelW +: VelW] <= sp[VelW-1:0];
                end
                if (sm > $signed({4'b0000, {(VelW-1){1'b1}}, 1'b1} >>> 1)) begin
                    r_out[(k+3)*VelW +: VelW] <= {1'b0, {(VelW-1){1'b1}}};
                end else if (sm < -$signed({4'b0000, 1'b1, {(VelW-1){1'b0}}})) begin
                    r_out[(k+3)*VelW +: VelW] <= {1'b1, {(VelW-1){1'b0}}};
                end else begin
                    r_out[(k+3)*VelW +: VelW] <= sm[VelW-1:0];
                end
            end
        end
    end

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a held output freezes every valid bit
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> r_vld == $past(r_vld))
        else $error("pipeline moved during stall");

    // polar sine never exceeds one
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[TrigReady] |-> sin_p <= (SqrtOutW'(1) << TrigFrac))
        else $error("polar sine out of range");

endmodule

// ===== tb/tb_isotropic_collision_velocities.sv =====
// testbench for the isotropic collision velocity pipeline: drives particle pairs,
// predicts post-collision velocities bit for bit and checks every result
// depends on icv_pkg and isotropic_collision_velocities
`timescale 1ns / 1ps

// holds predicted velocity sets and checks returned ones in order
class collision_scoreboard;
    logic [icv_pkg::OutDataW-1:0] pending_velocities[$];
    int mismatch_count;

    static function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bit_pos;
        res = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > n) bit_pos = bit_pos >> 2;
        while (bit_pos != 0) begin
            if (n >= res + bit_pos) begin
                n = n - (res + bit_pos);
                res = (res >> 1) + bit_pos;
            end else begin
                res = res >> 1;
            end
            bit_pos = bit_pos >> 2;
        end
        return res;
    endfunction

    static function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // post-collision velocities for one request
    static function automatic logic [icv_pkg::OutDataW-1:0] scatter_pair(
        logic [icv_pkg::InDataW-1:0] req);
        longint va[3], vb[3], cm[3], dir[3], ofs[3];
        longint unsigned quarter, low, radius, mag, sq, u, v, prod;
        longint cos_p, sin_p, x, y, z, xs, ys, cos_t, sin_t;
        logic [31:0] phase;
        logic [icv_pkg::OutDataW-1:0] res;
        quarter = 0;
        low = 0;
        for (int k = 0; k < 3; k++) begin
            va[k] = longint'($signed(req[32*k +: 32]));
            vb[k] = longint'($signed(req[32*(k+3) +: 32]));
            cm[k] = floor_shr(va[k] + vb[k], 1);
            x = va[k] - vb[k];
            mag = (x < 0) ? -x : x;
            sq = mag * mag;
            quarter += sq >> 2;
            low += sq & 3;
        end
        quarter += low >> 2;
        radius = int_sqrt(quarter);
        u = req[192 +: 16];
        v = req[208 +: 16];
        cos_p = (longint'(2 * v) - 65536) * (64'sd1 << 14);
        prod = (v * (65536 - v)) << 30;
        sin_p = longint'(int_sqrt(prod));
        phase = {u[15:0], 16'h0};
        z = phase[29:0];
        x = 652032874;
        y = 0;
        for (int i = 0; i < icv_pkg::CordicSteps; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(icv_pkg::turn_atan(i));
            end else begin
                x += ys; y -= xs; z += longint'(icv_pkg::turn_atan(i));
            end
        end
        case (phase[31:30])
            2'd0: begin cos_t = x; sin_t = y; end
            2'd1: begin cos_t = -y; sin_t = x; end
            2'd2: begin cos_t = -x; sin_t = -y; end
            default: begin cos_t = y; sin_t = -x; end
        endcase
        dir[0] = floor_shr(cos_t * sin_p, 30);
        dir[1] = floor_shr(sin_t * sin_p, 30);
        dir[2] = cos_p;
        for (int k = 0; k < 3; k++) begin
            ofs[k] = floor_shr(longint'(radius) * dir[k], 30);
            res[32*k +: 32] = clamp32(cm[k] + ofs[k]);
            res[32*(k+3) +: 32] = clamp32(cm[k] - ofs[k]);
        end
        return res;
    endfunction

    function void note_request(logic [icv_pkg::InDataW-1:0] req);
        pending_velocities.push_back(scatter_pair(req));
    endfunction

    function void check_result(logic [icv_pkg::OutDataW-1:0] got);
        logic [icv_pkg::OutDataW-1:0] want;
        if (pending_velocities.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_velocities.pop_front();
        for (int k = 0; k < 6; k++) begin
            if (got[32*k +: 32] !== want[32*k +: 32]) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("field %0d: expected %h, got %h", k,
                             want[32*k +: 32], got[32*k +: 32]);
            end
        end
    endfunction
endclass

module tb_isotropic_collision_velocities;
    import icv_pkg::*;

    localparam int CycleLimit = 400000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // first_vx, first_vy, first_vz, second_vx, second_vy, second_vz,
    // azimuth_fraction, polar_fraction
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // new_first_vx .. new_second_vz
    logic [OutDataW-1:0] m_axis_tdata;

    collision_scoreboard velocity_board;
    int  cycle_count;
    bit  hold_off_rx;

    isotropic_collision_velocities u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random velocity with a bias toward extremes and small values
    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 2000) - 1000;
            3: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [InDataW-1:0] random_pair();
        logic [InDataW-1:0] req;
        for (int k = 0; k < 6; k++) req[32*k +: 32] = pick_velocity();
        if ($urandom_range(0, 7) == 0) req[96 +: 96] = req[0 +: 96];
        req[192 +: 16] = 16'($urandom);
        req[208 +: 16] = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        return req;
    endfunction

    // offers one request and waits for it to be taken
    task automatic send_request(logic [InDataW-1:0] req);
        s_axis_tdata  <= req;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        velocity_board.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (velocity_board.pending_velocities.size() != 0) @(negedge i_clk);
    endtask

    // receiver stall pattern plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_rx) m_axis_tready <= 1'b0;
            else if (cycle_count % 1000 < 300) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checking on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            velocity_board.check_result(m_axis_tdata);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [InDataW-1:0] req;
        int burst;
        velocity_board = new();
        cycle_count   = 0;
        hold_off_rx   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, equal velocities, polar zero and edges, quadrants
        send_request('0);
        send_request({16'hffff, 16'hffff, {6{32'h7fffffff}}});
        send_request({16'h8000, 16'h0000, {3{32'h80000000}}, {3{32'h7fffffff}}});
        send_request({16'h0001, 16'h4000, {3{32'h7fffffff}}, {3{32'h80000000}}});
        send_request({16'h8000, 16'hc000, 96'h0, {3{32'h00010000}}});
        send_request({16'h0000, 16'h0001, {3{32'hffff0000}}, {3{32'h00010000}}});
        for (int q = 0; q < 8; q++) begin
            req = random_pair();
            req[192 +: 16] = 16'(q * 16'h2000);
            send_request(req);
        end
        for (int k = 0; k < 6; k++) begin
            req = '0;
            req[32*k +: 32] = 32'h80000000;
            req[208 +: 16] = 16'h5555;
            send_request(req);
        end
        req = random_pair();
        req[96 +: 96] = req[0 +: 96];
        send_request(req);

        // long receiver hold-off while the sender keeps offering
        hold_off_rx = 1'b1;
        fork
            begin
                int stall;
                stall = 0;
                while (stall < 150) begin
                    @(negedge i_clk);
                    stall++;
                end
                hold_off_rx = 1'b0;
            end
            for (int n = 0; n < 80; n++) send_request(random_pair());
        join
        wait_drained();

        // random bursts with gaps
        for (int n = 0; n < 1050; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) send_request(random_pair());
            n += burst;
            if ($urandom_range(0, 1)) idle_sender($urandom_range(1, 12));
            if (n > 500 && n < 545) wait_drained();
        end

        wait_drained();
        repeat (PipeDepth + 10) @(negedge i_clk);
        if (velocity_board.mismatch_count == 0 &&
            velocity_board.pending_velocities.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
